FILE: hdl/alist_pkg.sv
package alist_pkg;

    localparam int DATA_W          = 32;
    localparam int POS_W           = 6;
    localparam int REQ_W           = 2;
    localparam int STAT_W          = 2;
    localparam int MAX_LEN_DEFAULT = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 2'd0,
        REQ_DELETE   = 2'd1,
        REQ_LOCATE   = 2'd2,
        REQ_RETRIEVE = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_BAD_POS = 2'd2
    } stat_t;

endpackage

FILE: hdl/array_list_insert_delete.sv
// Rejected requests skip the walk and go straight to the result; insert and delete
//   shift the entries from pos onward, locate scans up to count entries, retrieve reads one.
// Throughput: one transaction at a time; the bound is the single read and single
//   write port of the element memory, one entry per cycle.
// The input is taken again as soon as a result sits in the output register.
// Reset (aresetn low, synchronous) clears the count and handshake state; memory
//   contents are not cleared and are only read below the count.
module array_list_insert_delete #(
    parameter int MAX_LEN = alist_pkg::MAX_LEN_DEFAULT
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [alist_pkg::REQ_W-1:0]             s_req_type,
    input  logic [alist_pkg::POS_W-1:0]             s_position,
    input  logic signed [alist_pkg::DATA_W-1:0]     s_value,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [alist_pkg::STAT_W-1:0]            m_status,
    output logic signed [alist_pkg::DATA_W-1:0]     m_read_value,
    output logic [alist_pkg::POS_W-1:0]             m_found_position,
    output logic [alist_pkg::POS_W-1:0]             m_item_total,
    output logic                                    m_is_empty,
    output logic                                    m_is_full
);
    import alist_pkg::*;

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t                 state_reg;
    req_t                   op_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [DATA_W-1:0]      val_reg;
    stat_t                  status_reg;
    logic [DATA_W-1:0]      rd_value_reg;
    logic [POS_W-1:0]       found_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       left_reg;
    logic [ADDR_W-1:0]      idx_reg;
    logic                   pend_reg;
    logic [ADDR_W-1:0]      pend_addr_reg;

    logic [DATA_W-1:0]      mem_ram [MAX_LEN];
    logic [DATA_W-1:0]      rdata_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [DATA_W-1:0]      mem_wdata;

    logic                   m_valid_reg;
    stat_t                  m_status_reg;
    logic [DATA_W-1:0]      m_read_value_reg;
    logic [POS_W-1:0]       m_found_reg;
    logic [POS_W-1:0]       m_total_reg;
    logic                   m_empty_reg;
    logic                   m_full_reg;

    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic [CMP_W-1:0]       cnt_new_ext;
    logic                   in_fire;
    logic                   load_out;
    logic                   loc_hit;

    assign pos_ext     = CMP_W'(s_position);
    assign cnt_ext     = CMP_W'(count_reg);
    assign in_fire     = s_valid && s_ready;
    assign s_ready     = (state_reg == S_IDLE);
    assign load_out    = (state_reg == S_RESP) && (!m_valid_reg || m_ready);
    assign loc_hit     = (op_reg == REQ_LOCATE) && pend_reg && (rdata_reg == val_reg);
    assign cnt_new_ext = CMP_W'(count_next);

    always_comb begin
        count_next = count_reg;
        if (status_reg == STAT_OK) begin
            if (op_reg == REQ_INSERT) begin
                count_next = count_reg + CNT_W'(1);
            end else if (op_reg == REQ_DELETE) begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    // Pending shifted word goes first; the new element lands once the walk has drained.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = rdata_reg;
        if (state_reg == S_WALK) begin
            if (pend_reg && (op_reg == REQ_INSERT || op_reg == REQ_DELETE)) begin
                mem_we = 1'b1;
            end else if (!pend_reg && left_reg == '0 && op_reg == REQ_INSERT) begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(CMP_W'(pos_reg) - CMP_W'(1));
                mem_wdata = val_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_ram[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem_ram[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !load_out) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        op_reg       <= req_t'(s_req_type);
                        pos_reg      <= s_position;
                        val_reg      <= s_value;
                        rd_value_reg <= '0;
                        found_reg    <= '0;
                        pend_reg     <= 1'b0;
                        unique case (req_t'(s_req_type))
                            REQ_INSERT: begin
                                left_reg <= CNT_W'(cnt_ext - pos_ext + CMP_W'(1));
                                idx_reg  <= ADDR_W'(cnt_ext - CMP_W'(1));
                                if (cnt_ext == CMP_W'(MAX_LEN)) begin
                                    status_reg <= STAT_FULL;
                                    state_reg  <= S_RESP;
                                end else if (pos_ext == '0 ||
                                             pos_ext > cnt_ext + CMP_W'(1)) begin
                                    status_reg <= STAT_BAD_POS;
                                    state_reg  <= S_RESP;
                                end else begin
                                    status_reg <= STAT_OK;
                                    state_reg  <= S_WALK;
                                end
                            end
                            REQ_DELETE: begin
                                left_reg <= CNT_W'(cnt_ext - pos_ext);
                                idx_reg  <= ADDR_W'(pos_ext);
                                if (pos_ext == '0 || pos_ext > cnt_ext) begin
                                    status_reg <= STAT_BAD_POS;
                                    state_reg  <= S_RESP;
                                end else begin
                                    status_reg <= STAT_OK;
                                    state_reg  <= S_WALK;
                                end
                            end
                            REQ_LOCATE: begin
                                left_reg   <= count_reg;
                                idx_reg    <= '0;
                                status_reg <= STAT_OK;
                                state_reg  <= S_WALK;
                            end
                            REQ_RETRIEVE: begin
                                left_reg <= CNT_W'(1);
                                idx_reg  <= ADDR_W'(pos_ext - CMP_W'(1));
                                if (pos_ext == '0 || pos_ext > cnt_ext) begin
                                    status_reg <= STAT_BAD_POS;
                                    state_reg  <= S_RESP;
                                end else begin
                                    status_reg <= STAT_OK;
                                    state_reg  <= S_WALK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK: begin
                    if (op_reg == REQ_RETRIEVE && pend_reg) begin
                        rd_value_reg <= rdata_reg;
                    end
                    priority if (loc_hit) begin
                        found_reg <= POS_W'(CMP_W'(pend_addr_reg) + CMP_W'(1));
                        pend_reg  <= 1'b0;
                        left_reg  <= '0;
                        state_reg <= S_RESP;
                    end else if (left_reg != '0) begin
                        pend_reg <= 1'b1;
                        left_reg <= left_reg - CNT_W'(1);
                        unique case (op_reg)
                            REQ_INSERT: begin
                                pend_addr_reg <= idx_reg + ADDR_W'(1);
                                idx_reg       <= idx_reg - ADDR_W'(1);
                            end
                            REQ_DELETE: begin
                                pend_addr_reg <= idx_reg - ADDR_W'(1);
                                idx_reg       <= idx_reg + ADDR_W'(1);
                            end
                            default: begin
                                pend_addr_reg <= idx_reg;
                                idx_reg       <= idx_reg + ADDR_W'(1);
                            end
                        endcase
                    end else begin
                        pend_reg <= 1'b0;
                        if (!pend_reg) begin
                            if (op_reg == REQ_LOCATE) begin
                                found_reg <= POS_W'(cnt_ext + CMP_W'(1));
                            end
                            state_reg <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    // Hold the result until the output register is free.
                    if (load_out) begin
                        m_valid_reg      <= 1'b1;
                        m_status_reg     <= status_reg;
                        m_read_value_reg <= rd_value_reg;
                        m_found_reg      <= found_reg;
                        m_total_reg      <= POS_W'(cnt_new_ext);
                        m_empty_reg      <= (count_next == '0);
                        m_full_reg       <= (cnt_new_ext == CMP_W'(MAX_LEN));
                        count_reg        <= count_next;
                        state_reg        <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_read_value     = m_read_value_reg;
    assign m_found_position = m_found_reg;
    assign m_item_total     = m_total_reg;
    assign m_is_empty       = m_empty_reg;
    assign m_is_full        = m_full_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(MAX_LEN))
        else $error("entry count above capacity");

    a_write_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_WALK))
        else $error("memory written outside the walk");

    a_count_only_on_resp: assert property (@(posedge aclk)
        aresetn && $past(aresetn) && $past(state_reg != S_RESP) |->
            count_reg == $past(count_reg))
        else $error("count changed outside the response step");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_status_reg))
        else $error("pending result dropped");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_found_reg != '0 |-> m_status_reg == STAT_OK)
        else $error("locate answer with error status");

endmodule
